### rtl/mmhq_pkg.sv
package mmhq_pkg;

   localparam int ValueWidth = 32;
   localparam int CountWidth = 11;

   typedef logic [1:0] op_type;
   localparam op_type OpInsert    = 2'd0;
   localparam op_type OpRemoveMin = 2'd1;
   localparam op_type OpRemoveMax = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type StatusDone  = 2'd0;
   localparam status_type StatusFull  = 2'd1;
   localparam status_type StatusEmpty = 2'd2;

   typedef logic signed [ValueWidth-1:0] value_type;

endpackage

### rtl/min_max_heap_queue_unit.sv
// Channel   Direction  Payload
// req_      in         tdata = {value[33:2], op[1:0]}, 40 bits
// rsp_      out        tdata = {status, count, max, min, removed}, 112 bits
//
// One memory port is shared by a small sequencer; every heap read passes
// through an address state and a registered-data state (S_RD, S_RW), and
// every write is made from the state that issues it. A removal sinks the
// moved value a pair of levels at a time, and a maximum removal first
// compares the two children of the root to find the largest element.
// Reset clears the state, fill count and response valid only; the store needs no clearing pass.
// The block takes no request while busy or while a response waits.
module min_max_heap_queue_unit #(
   parameter int CAPACITY = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // op[1:0], value[33:2], zeros
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata    // removed, min, max, count[106:96], status
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NW = $clog2(CAPACITY + 1);
   localparam int XW = NW + 3;

   localparam logic [4:0] S_IDLE = 5'd0,  S_RD = 5'd1,  S_RW = 5'd2,
      S_INS = 5'd3,  S_BU = 5'd4,  S_BG = 5'd5,  S_BGC = 5'd6,
      S_RM = 5'd7,   S_RMX = 5'd8, S_RMS = 5'd9, S_TD = 5'd10,
      S_TDC = 5'd11, S_TDF = 5'd12, S_TDP = 5'd13, S_SUM = 5'd14,
      S_SUM1 = 5'd15, S_SUM2 = 5'd16, S_OUT = 5'd17, S_TDS = 5'd18;

   logic [4:0] state_ff, state_in, ret_ff, ret_in;
   logic signed [31:0] mem [CAPACITY];
   logic [AW-1:0] addr;
   logic we;
   logic signed [31:0] wdata, rdata_ff;

   logic [NW-1:0] n_ff, n_in;
   logic [XW-1:0] i_ff, i_in, k_ff, k_in, best_ff, best_in;
   logic signed [31:0] vi_ff, vi_in, vb_ff, vb_in, rem_ff, rem_in;
   logic signed [31:0] mn_ff, mn_in, mx_ff, mx_in;
   logic want_max_ff, want_max_in, grand_ff, grand_in;
   logic [1:0] st_ff, st_in;
   logic [XW-1:0] rd_addr_ff, rd_addr_in;
   logic signed [31:0] tmp_ff, tmp_in;
   logic out_valid_ff, out_valid_in;

   // Shared comparator.
   logic signed [31:0] ca, cb;
   logic gt;
   assign gt = ca > cb;

   function automatic logic min_level(input logic [XW-1:0] idx);
      logic [XW:0] x;
      logic lvl;
      x = {1'b0, idx} + 1'b1;
      lvl = 1'b0;
      for (int b = 0; b <= XW; b++) begin
         if (x[b]) begin
            lvl = b[0];
         end
      end
      return !lvl;
   endfunction

   function automatic logic [XW-1:0] parent(input logic [XW-1:0] idx);
      return (idx - 1'b1) >> 1;
   endfunction

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; n_in = n_ff; i_in = i_ff; k_in = k_ff;
      best_in = best_ff; vi_in = vi_ff; vb_in = vb_ff; rem_in = rem_ff;
      mn_in = mn_ff; mx_in = mx_ff; want_max_in = want_max_ff; grand_in = grand_ff;
      st_in = st_ff; rd_addr_in = rd_addr_ff; tmp_in = tmp_ff;
      out_valid_in = out_valid_ff;
      addr = rd_addr_ff[AW-1:0]; we = 1'b0; wdata = vi_ff;
      ca = vi_ff; cb = rdata_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               st_in = mmhq_pkg::StatusDone; rem_in = '0;
               vi_in = req_tdata[33:2];
               state_in = S_SUM;
               case (req_tdata[1:0])
                  mmhq_pkg::OpInsert: begin
                     if (n_ff >= NW'(CAPACITY)) begin
                        st_in = mmhq_pkg::StatusFull;
                     end else begin
                        state_in = S_INS;
                     end
                  end
                  mmhq_pkg::OpRemoveMin, mmhq_pkg::OpRemoveMax: begin
                     if (n_ff == '0) begin
                        st_in = mmhq_pkg::StatusEmpty;
                     end else if (req_tdata[1:0] == mmhq_pkg::OpRemoveMin || n_ff == NW'(1)) begin
                        best_in = '0; state_in = S_RM;
                     end else if (n_ff == NW'(2)) begin
                        best_in = XW'(1); state_in = S_RM;
                     end else begin
                        rd_addr_in = XW'(1); ret_in = S_RMX; state_in = S_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            state_in = S_RW;
         end
         S_RW: begin
            state_in = ret_ff;
         end
         S_INS: begin
            // Write the new value at the end, then compare with its parent.
            addr = n_ff[AW-1:0]; we = 1'b1;
            i_in = XW'(n_ff); n_in = n_ff + 1'b1;
            if (n_ff == '0) begin
               state_in = S_SUM;
            end else begin
               rd_addr_in = parent(XW'(n_ff)); ret_in = S_BU; state_in = S_RD;
            end
         end
         S_BU: begin
            if (min_level(i_ff) ? gt : (rdata_ff > vi_ff)) begin
               addr = i_ff[AW-1:0]; we = 1'b1; wdata = rdata_ff;
               i_in = rd_addr_ff; want_max_in = min_level(i_ff);
            end else begin
               want_max_in = !min_level(i_ff);
            end
            state_in = S_BG;
         end
         S_BG: begin
            if (i_ff >= XW'(3)) begin
               rd_addr_in = parent(parent(i_ff)); ret_in = S_BGC; state_in = S_RD;
            end else begin
               addr = i_ff[AW-1:0]; we = 1'b1; state_in = S_SUM;
            end
         end
         S_BGC: begin
            if (want_max_ff ? gt : (rdata_ff > vi_ff)) begin
               addr = i_ff[AW-1:0]; we = 1'b1; wdata = rdata_ff;
               i_in = rd_addr_ff; state_in = S_BG;
            end else begin
               addr = i_ff[AW-1:0]; we = 1'b1; state_in = S_SUM;
            end
         end
         S_RMX: begin
            tmp_in = rdata_ff; rd_addr_in = XW'(2); ret_in = S_RMS; state_in = S_RD;
         end
         S_RMS: begin
            ca = rdata_ff; cb = tmp_ff;
            best_in = gt ? XW'(2) : XW'(1); state_in = S_RM;
         end
         S_RM: begin
            // Read the removed value, then the last element.
            rd_addr_in = best_ff; ret_in = S_TDS; state_in = S_RD;
         end
         S_TDS: begin
            rem_in = rdata_ff; n_in = n_ff - 1'b1; i_in = best_ff;
            want_max_in = !min_level(best_ff);
            if (best_ff < XW'(n_ff - 1'b1)) begin
               rd_addr_in = XW'(n_ff - 1'b1); ret_in = S_TD; state_in = S_RD;
               k_in = '1;
            end else begin
               state_in = S_SUM;
            end
         end
         S_TD: begin
            // vi holds the sinking value; scan children then grandchildren.
            if (k_ff == '1) begin
               vi_in = rdata_ff;
            end
            if ((i_ff << 1) + 1'b1 >= XW'(n_ff)) begin
               addr = i_ff[AW-1:0]; we = 1'b1; state_in = S_SUM;
               if (k_ff == '1) begin
                  wdata = rdata_ff;
               end
            end else begin
               best_in = (i_ff << 1) + 1'b1; grand_in = 1'b0;
               rd_addr_in = (i_ff << 1) + 1'b1; k_in = (i_ff << 1) + 1'b1;
               ret_in = S_TDC; state_in = S_RD;
            end
         end
         S_TDC: begin
            ca = rdata_ff; cb = vb_ff;
            if (k_ff == (i_ff << 1) + 1'b1 ||
                (want_max_ff ? gt : (vb_ff > rdata_ff))) begin
               vb_in = rdata_ff; best_in = k_ff;
               grand_in = k_ff > (i_ff << 1) + XW'(2);
            end
            k_in = (k_ff == (i_ff << 1) + XW'(2)) ? (i_ff << 2) + XW'(3) : k_ff + 1'b1;
            if (k_in > (i_ff << 2) + XW'(6) || k_in >= XW'(n_ff)) begin
               state_in = S_TDF;
            end else begin
               rd_addr_in = k_in; state_in = S_RD;
            end
         end
         S_TDF: begin
            ca = vb_ff; cb = vi_ff;
            if (want_max_ff ? gt : (vi_ff > vb_ff)) begin
               addr = i_ff[AW-1:0]; we = 1'b1; wdata = vb_ff;
               if (!grand_ff) begin
                  i_in = best_ff; state_in = S_TDP;
               end else begin
                  rd_addr_in = parent(best_ff); ret_in = S_TDP; state_in = S_RD;
               end
            end else begin
               addr = i_ff[AW-1:0]; we = 1'b1; state_in = S_SUM;
            end
         end
         S_TDP: begin
            if (!grand_ff) begin
               addr = i_ff[AW-1:0]; we = 1'b1; state_in = S_SUM;
            end else begin
               i_in = best_ff; k_in = '0;
               if (want_max_ff ? (rdata_ff > vi_ff) : gt) begin
                  addr = rd_addr_ff[AW-1:0]; we = 1'b1;
                  vi_in = rdata_ff;
               end
               state_in = S_TD;
            end
         end
         S_SUM: begin
            mn_in = '0; mx_in = '0;
            if (n_ff != '0) begin
               rd_addr_in = '0; ret_in = S_SUM1; state_in = S_RD;
            end else begin
               state_in = S_OUT; out_valid_in = 1'b1;
            end
         end
         S_SUM1: begin
            mn_in = rdata_ff; mx_in = rdata_ff;
            if (n_ff >= NW'(2)) begin
               rd_addr_in = XW'(1); ret_in = S_SUM2; state_in = S_RD;
            end else begin
               state_in = S_OUT; out_valid_in = 1'b1;
            end
         end
         S_SUM2: begin
            ca = rdata_ff; cb = mx_ff;
            if (rd_addr_ff == XW'(1) || gt) begin
               mx_in = rdata_ff;
            end
            if (rd_addr_ff == XW'(1) && n_ff >= NW'(3)) begin
               rd_addr_in = XW'(2); state_in = S_RD;
            end else begin
               state_in = S_OUT; out_valid_in = 1'b1;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               out_valid_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; n_ff <= '0; out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; n_ff <= n_in; out_valid_ff <= out_valid_in;
      end
      ret_ff <= ret_in; i_ff <= i_in; k_ff <= k_in; best_ff <= best_in;
      vi_ff <= vi_in; vb_ff <= vb_in; rem_ff <= rem_in; mn_ff <= mn_in;
      mx_ff <= mx_in; want_max_ff <= want_max_in; grand_ff <= grand_in;
      st_ff <= st_in; rd_addr_ff <= rd_addr_in; tmp_ff <= tmp_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, st_ff, mmhq_pkg::CountWidth'(n_ff), mx_ff, mn_ff, rem_ff};

endmodule
